[design/bcau_pkg.sv]
// Package for the braille chord assembler: field widths, register indexes,
// reset values and the structs passed between the top level and the step logic.
// No dependencies.
package bcau_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned DotsW  = 8;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] DotMaskRst     = 16'd63;
  localparam logic [CfgW-1:0] HoldTimeoutRst = 16'd2000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DOT_MASK     = 2'd0,
    CFG_HOLD_TIMEOUT = 2'd1
  } cfg_idx_e;

  // Chord tracking state carried from item to item.
  typedef struct packed {
    logic [KeyW-1:0]  last_keys;
    logic [DotsW-1:0] chord_bits;
    logic             chord_open;
    logic [TimeW-1:0] chord_start_time;
  } chord_state_t;

  // One input item.
  typedef struct packed {
    logic [KeyW-1:0]  key_snapshot;
    logic             snapshot_changed;
    logic [TimeW-1:0] time_ms;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic             matrix_valid;
    logic [KeyW-1:0]  matrix_keys;
    logic             chord_valid;
    logic [DotsW-1:0] chord_dots;
  } out_item_t;

endpackage

[design/bcau_in_if.sv]
// Input channel of the chord assembler: valid/ready handshake and the key item.
// Depends on bcau_pkg for field widths.
interface bcau_in_if;
  logic                        valid;
  logic                        ready;
  logic [bcau_pkg::KeyW-1:0]   key_snapshot;
  logic                        snapshot_changed;
  logic [bcau_pkg::TimeW-1:0]  time_ms;

  modport source (output valid, key_snapshot, snapshot_changed, time_ms, input ready);
  modport sink   (input valid, key_snapshot, snapshot_changed, time_ms, output ready);
endinterface

[design/bcau_out_if.sv]
// Result channel of the chord assembler: valid/ready handshake and the result item.
// Depends on bcau_pkg for field widths.
interface bcau_out_if;
  logic                        valid;
  logic                        ready;
  logic                        matrix_valid;
  logic [bcau_pkg::KeyW-1:0]   matrix_keys;
  logic                        chord_valid;
  logic [bcau_pkg::DotsW-1:0]  chord_dots;

  modport source (output valid, matrix_valid, matrix_keys, chord_valid, chord_dots,
                  input ready);
  modport sink   (input valid, matrix_valid, matrix_keys, chord_valid, chord_dots,
                  output ready);
endinterface

[design/bcau_step.sv]
// Combinational update for one item: matrix forwarding, chord accumulation,
// release commit and hold timeout commit. Depends on bcau_pkg.
module bcau_step (
  input  bcau_pkg::in_item_t          item_i,
  input  bcau_pkg::chord_state_t      state_i,
  input  logic [bcau_pkg::CfgW-1:0]   dot_mask_i,
  input  logic [bcau_pkg::CfgW-1:0]   hold_timeout_i,
  output bcau_pkg::chord_state_t      state_o,
  output bcau_pkg::out_item_t         result_o
);
  import bcau_pkg::*;

  logic [KeyW-1:0]  diff;
  logic [KeyW-1:0]  dot_keys;
  logic             chg;
  logic             press_seen;
  logic             open1;
  logic [TimeW-1:0] start1;
  logic [DotsW-1:0] bits1;
  logic             release_commit;
  logic             open2;
  logic [TimeW-1:0] start2;
  logic [DotsW-1:0] bits2;
  logic [TimeW-1:0] elapsed;
  logic             timeout_commit;

  // Key differences against the last examined snapshot.
  assign chg        = item_i.snapshot_changed;
  assign diff       = state_i.last_keys ^ item_i.key_snapshot;
  assign dot_keys   = item_i.key_snapshot & dot_mask_i;
  assign press_seen = chg && ((diff & dot_keys) != '0);

  // A new dot press opens the chord and ORs the pressed dots in.
  assign open1  = state_i.chord_open | press_seen;
  assign start1 = (press_seen && !state_i.chord_open) ? item_i.time_ms
                                                      : state_i.chord_start_time;
  assign bits1  = press_seen ? (state_i.chord_bits | dot_keys[DotsW-1:0])
                             : state_i.chord_bits;

  // Releasing every dot key commits the chord.
  assign release_commit = chg && open1 && (dot_keys == '0);
  assign open2  = release_commit ? 1'b0 : open1;
  assign start2 = release_commit ? '0 : start1;
  assign bits2  = release_commit ? '0 : bits1;

  // Hold timeout, skipped while the start time is zero; wraps modulo 2^64.
  assign elapsed        = item_i.time_ms - start2;
  assign timeout_commit = open2 && (start2 != '0) &&
                          (elapsed >= {{(TimeW-CfgW){1'b0}}, hold_timeout_i});

  // Next state.
  always_comb begin
    state_o.last_keys        = chg ? item_i.key_snapshot : state_i.last_keys;
    state_o.chord_open       = timeout_commit ? 1'b0 : open2;
    state_o.chord_start_time = timeout_commit ? '0 : start2;
    state_o.chord_bits       = timeout_commit ? '0 : bits2;
  end

  // Result item.
  always_comb begin
    result_o.matrix_valid = chg && ((diff & ~dot_mask_i) != '0);
    result_o.matrix_keys  = result_o.matrix_valid ? item_i.key_snapshot : '0;
    result_o.chord_valid  = 1'b0;
    result_o.chord_dots   = '0;
    if (release_commit && (bits1 != '0)) begin
      result_o.chord_valid = 1'b1;
      result_o.chord_dots  = bits1;
    end else if (timeout_commit && (bits2 != '0)) begin
      result_o.chord_valid = 1'b1;
      result_o.chord_dots  = bits2;
    end
  end

endmodule

[design/braille_chord_assembler_unit.sv]
// Top level of the braille chord assembler: input register, chord state,
// configuration registers and result register. Depends on bcau_pkg,
// bcau_in_if, bcau_out_if and bcau_step.
//
//   Channel   Dir   Handshake       Payload
//   in_i      in    valid/ready     key_snapshot, snapshot_changed, time_ms
//   out_o     out   valid/ready     matrix_valid, matrix_keys, chord_valid, chord_dots
//   cfg       in    cfg_we_i        cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while out_o.ready is high. The result is offered
// once the accepted item moves from the input register into the result register.
// The chord state updates as the item moves into the result register.
// A stalled result register holds the item in the input register; while the
// result waits, input is taken only if the input register is empty.
// Reset clears the chord state and loads dot_mask 63, hold_timeout_ms 2000.
module braille_chord_assembler_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bcau_in_if.sink                        in_i,
  bcau_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [bcau_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bcau_pkg::CfgW-1:0]      cfg_wdata_i
);
  import bcau_pkg::*;

  logic         in_valid_q;
  in_item_t     in_item_q;
  logic         out_valid_q;
  out_item_t    out_item_q;
  chord_state_t state_q;
  chord_state_t state_d;
  out_item_t    result_d;
  logic [CfgW-1:0] dot_mask_q;
  logic [CfgW-1:0] hold_timeout_q;
  logic         advance;
  logic         in_take;

  // Handshake control.
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_mask_q     <= DotMaskRst;
      hold_timeout_q <= HoldTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DOT_MASK:     dot_mask_q     <= cfg_wdata_i;
        CFG_HOLD_TIMEOUT: hold_timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.key_snapshot     <= in_i.key_snapshot;
      in_item_q.snapshot_changed <= in_i.snapshot_changed;
      in_item_q.time_ms          <= in_i.time_ms;
    end
  end

  // Per-item update.
  bcau_step u_step (
    .item_i         (in_item_q),
    .state_i        (state_q),
    .dot_mask_i     (dot_mask_q),
    .hold_timeout_i (hold_timeout_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  // Chord state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.matrix_valid = out_item_q.matrix_valid;
  assign out_o.matrix_keys  = out_item_q.matrix_keys;
  assign out_o.chord_valid  = out_item_q.chord_valid;
  assign out_o.chord_dots   = out_item_q.chord_dots;

endmodule
